@@ rtl/core/sasp_pkg.sv @@
package sasp_pkg;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SOURCE_ACTIVE = 3'd0,
    CFG_FALLOFF_FACTOR = 3'd1,
    CFG_FALLOFF_POWER = 3'd2,
    CFG_CUTOFF_LEVEL = 3'd3,
    CFG_BASE_VOLUME = 3'd4
  } cfg_idx_e;

  // operations of the shared divide / square root unit
  typedef enum logic {
    DSU_DIV = 1'b0,
    DSU_SQRT = 1'b1
  } dsu_op_e;

  localparam int unsigned DsuNumWidth = 64;
  localparam int unsigned DsuDenWidth = 48;

  typedef struct packed {
    logic start;
    dsu_op_e op;
  } dsu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsu_sts_t;

  localparam logic [15:0] PitchOne = 16'd4096;
  localparam logic [15:0] PitchMax = 16'd65535;
  localparam logic [11:0] PitchDen = 12'd3333;

endpackage

@@ rtl/core/sasp_if.sv @@
interface sasp_in_if;
  logic valid;
  logic ready;
  logic [23:0] frame_time;
  logic [62:0] object_position;
  logic [62:0] last_object_position;
  logic [62:0] listener_position;
  logic [62:0] last_listener_position;
  logic [62:0] listener_right;

  modport source (
    output valid, frame_time, object_position, last_object_position,
    output listener_position, last_listener_position, listener_right,
    input ready
  );
  modport sink (
    input valid, frame_time, object_position, last_object_position,
    input listener_position, last_listener_position, listener_right,
    output ready
  );
endinterface

interface sasp_out_if;
  logic valid;
  logic ready;
  logic audible;
  logic [15:0] volume_out;
  logic [15:0] left_gain;
  logic [15:0] right_gain;
  logic [15:0] pitch_out;

  modport source (
    output valid, audible, volume_out, left_gain, right_gain, pitch_out,
    input ready
  );
  modport sink (
    input valid, audible, volume_out, left_gain, right_gain, pitch_out,
    output ready
  );
endinterface

@@ rtl/core/sasp_divsqrt.sv @@
module sasp_divsqrt import sasp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dsu_req_t               req_i,
  input  logic [DsuNumWidth-1:0] num_i,
  input  logic [DsuDenWidth-1:0] den_i,
  output dsu_sts_t               sts_o,
  output logic [DsuNumWidth-1:0] res_o
);

  localparam int unsigned SubW = DsuNumWidth + 2;
  localparam int unsigned RootW = DsuNumWidth / 2;
  localparam int unsigned CntW = $clog2(DsuNumWidth);

  logic busy_q, done_q;
  dsu_op_e op_q;
  logic [CntW-1:0] cnt_q;
  logic [DsuNumWidth-1:0] quo_q;
  logic [SubW-1:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [DsuDenWidth-1:0] den_q;

  logic [SubW-1:0] sub_a, sub_b;
  logic [SubW:0] sub_r;
  logic ge, last;

  // one compare / subtract serves both operations
  always_comb begin
    if (op_q == DSU_DIV) begin
      sub_a = {rem_q[SubW-2:0], quo_q[DsuNumWidth-1]};
      sub_b = SubW'(den_q);
      last = (cnt_q == CntW'(DsuNumWidth - 1));
    end else begin
      sub_a = {rem_q[SubW-3:0], quo_q[DsuNumWidth-1 -: 2]};
      sub_b = SubW'({root_q, 2'b01});
      last = (cnt_q == CntW'(RootW - 1));
    end
    sub_r = {1'b0, sub_a} - {1'b0, sub_b};
    ge = !sub_r[SubW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q <= DSU_DIV;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q <= req_i.op;
        cnt_q <= '0;
        quo_q <= num_i;
        rem_q <= '0;
        root_q <= '0;
        den_q <= den_i;
      end else if (busy_q) begin
        rem_q <= ge ? sub_r[SubW-1:0] : sub_a;
        if (op_q == DSU_DIV) begin
          quo_q <= {quo_q[DsuNumWidth-2:0], ge};
        end else begin
          quo_q <= {quo_q[DsuNumWidth-3:0], 2'b00};
          root_q <= {root_q[RootW-2:0], ge};
        end
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = (op_q == DSU_DIV) ? quo_q : DsuNumWidth'(root_q);

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running operation");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("start while busy");
  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("busy and done together");

endmodule

@@ rtl/core/spatial_audio_source_params.sv @@
// Positional audio source: attenuation, stereo pan and Doppler pitch.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, one
// register per cycle; the user must write it only while the block is idle,
// which the block itself does not enforce. Input items arrive on in_if
// (valid/ready) carrying frame time, source and listener positions for this
// frame and the last one, and the listener's right vector. One result item
// per accepted input leaves on out_if while source_active is set; with
// source_active clear the item is taken and dropped.
// in_if.ready is high only while the sequencer is idle. All the square roots
// and divisions run on one shared radix-2 unit. An inaudible item skips the
// volume, pan and pitch steps; the first audible update skips the pitch
// step, and a distance at its floor skips the pan step.
// The result sits in an output register: the next item can be taken while
// it waits, and a stalled receiver only holds the sequencer at its final
// step until the register frees up.
// Reset restores the register defaults, clears the output valid flag and
// marks the motion history as empty, so the first audible pitch is one.
module spatial_audio_source_params import sasp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 21,
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  sasp_in_if.sink                 in_if,
  sasp_out_if.source              out_if
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned G = GAIN_FRAC_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned MW = 25;
  localparam logic [G:0] GainOne = (G+1)'(1) << G;
  localparam logic [G:0] GainHalf = (G+1)'(1) << (G - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ACC, S_SQRT, S_WAIT, S_DIST, S_ATT_DIV, S_ATT_NEXT,
    S_ATT_CHK, S_VMUL, S_VOL, S_DOT_DIV, S_MIX, S_PITCH0, S_PREV, S_PMUL,
    S_PDIV, S_PITCH, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_SQ_CUR, PH_DOT, PH_SQ_PREV
  } phase_e;

  // configuration
  logic active_q;
  logic [31:0] factor_q;
  logic [1:0] power_q;
  logic [15:0] cutoff_q;
  logic [15:0] base_q;

  state_e state_q, ret_q;
  phase_e ph_q;
  logic [1:0] k_q, pc_q;
  logic first_q;
  logic [23:0] t_q;
  logic signed [DW-1:0] od_q [3];
  logic signed [DW-1:0] pd_q [3];
  logic signed [CW-1:0] rt_q [3];
  logic signed [63:0] acc_q;
  logic signed [2*MW-1:0] mul_q;
  logic [DW-1:0] d_q, dprev_q;
  logic [63:0] att_q;
  logic [G:0] attc_q;
  logic neg_q;
  logic aud_q;
  logic [15:0] vol_q, pitch_q;
  logic [G:0] mix_q;

  logic out_valid_q, out_aud_q;
  logic [15:0] out_vol_q, out_lg_q, out_rg_q, out_pitch_q;

  logic signed [MW-1:0] mul_a, mul_b;
  dsu_req_t dsu_req;
  dsu_sts_t dsu_sts;
  logic [DsuNumWidth-1:0] dsu_num, dsu_res;
  logic [DsuDenWidth-1:0] dsu_den;

  logic [1:0] pe;
  logic [5:0] num_sh;
  logic [63:0] num_full, dot_mag;
  logic signed [DW:0] delta;
  logic [DW:0] delta_mag;
  logic [G:0] att_cap;
  logic signed [64:0] q_s, mix_w, pitch_w;
  logic in_acc, out_free;

  assign in_acc = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    pe = (power_q == 2'd0) ? 2'd1 : power_q;
    num_sh = 6'(8 * int'(pe) + int'(G) - 16);
    num_full = 64'(factor_q) << num_sh;
    dot_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    delta = $signed({1'b0, dprev_q}) - $signed({1'b0, d_q});
    delta_mag = delta[DW] ? (DW+1)'(-delta) : (DW+1)'(delta);
    att_cap = (att_q > 64'(GainOne)) ? GainOne : att_q[G:0];
    q_s = neg_q ? -$signed({1'b0, dsu_res}) : $signed({1'b0, dsu_res});
    mix_w = $signed(65'(GainHalf)) - q_s;
    pitch_w = $signed(65'(PitchOne)) + q_s;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL: begin
        case (ph_q)
          PH_SQ_CUR: begin
            mul_a = MW'(od_q[k_q]);
            mul_b = MW'(od_q[k_q]);
          end
          PH_SQ_PREV: begin
            mul_a = MW'(pd_q[k_q]);
            mul_b = MW'(pd_q[k_q]);
          end
          default: begin
            mul_a = MW'(od_q[k_q]);
            mul_b = MW'(rt_q[k_q]);
          end
        endcase
      end
      S_VMUL: begin
        mul_a = $signed(MW'(attc_q));
        mul_b = $signed(MW'(base_q));
      end
      S_PMUL: begin
        mul_a = $signed(MW'((t_q == 24'd0) ? 24'd1 : t_q));
        mul_b = $signed(MW'(PitchDen));
      end
      default: ;
    endcase
  end

  always_comb begin
    dsu_req = '{start: 1'b0, op: DSU_DIV};
    dsu_num = '0;
    dsu_den = '0;
    case (state_q)
      S_SQRT: begin
        dsu_req = '{start: 1'b1, op: DSU_SQRT};
        dsu_num = 64'(acc_q);
      end
      S_ATT_DIV: begin
        dsu_req = '{start: 1'b1, op: DSU_DIV};
        dsu_num = (pc_q == 2'd1) ? num_full : att_q;
        dsu_den = DsuDenWidth'(d_q);
      end
      S_DOT_DIV: begin
        dsu_req = '{start: 1'b1, op: DSU_DIV};
        dsu_num = dot_mag << (G - 1);
        dsu_den = DsuDenWidth'(d_q) << (CW - 2);
      end
      S_PDIV: begin
        dsu_req = '{start: 1'b1, op: DSU_DIV};
        // |delta| * 2560 * 4096
        dsu_num = (64'(delta_mag) << 23) + (64'(delta_mag) << 21);
        dsu_den = DsuDenWidth'(mul_q[DsuDenWidth-1:0]);
      end
      default: ;
    endcase
  end

  sasp_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dsu_req),
    .num_i  (dsu_num),
    .den_i  (dsu_den),
    .sts_o  (dsu_sts),
    .res_o  (dsu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      factor_q <= 32'd65536;
      power_q <= 2'd1;
      cutoff_q <= 16'd0;
      base_q <= 16'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_ACTIVE: active_q <= cfg_data_i[0];
        CFG_FALLOFF_FACTOR: factor_q <= cfg_data_i;
        CFG_FALLOFF_POWER: power_q <= cfg_data_i[1:0];
        CFG_CUTOFF_LEVEL: cutoff_q <= cfg_data_i[15:0];
        CFG_BASE_VOLUME: base_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      ph_q <= PH_SQ_CUR;
      k_q <= '0;
      pc_q <= '0;
      first_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && active_q) begin
            t_q <= in_if.frame_time;
            for (int i = 0; i < 3; i++) begin
              od_q[i] <= $signed({in_if.object_position[i*CW+CW-1],
                                  in_if.object_position[i*CW +: CW]})
                       - $signed({in_if.listener_position[i*CW+CW-1],
                                  in_if.listener_position[i*CW +: CW]});
              pd_q[i] <= $signed({in_if.last_object_position[i*CW+CW-1],
                                  in_if.last_object_position[i*CW +: CW]})
                       - $signed({in_if.last_listener_position[i*CW+CW-1],
                                  in_if.last_listener_position[i*CW +: CW]});
              rt_q[i] <= in_if.listener_right[i*CW +: CW];
            end
            acc_q <= '0;
            k_q <= '0;
            ph_q <= PH_SQ_CUR;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          acc_q <= acc_q + 64'(mul_q);
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= (ph_q == PH_DOT) ? S_DOT_DIV : S_SQRT;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_SQRT: begin
          ret_q <= (ph_q == PH_SQ_CUR) ? S_DIST : S_PREV;
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (dsu_sts.done) state_q <= ret_q;
        end
        S_DIST: begin
          d_q <= (dsu_res == '0) ? DW'(1) : dsu_res[DW-1:0];
          pc_q <= 2'd1;
          state_q <= S_ATT_DIV;
        end
        S_ATT_DIV: begin
          ret_q <= S_ATT_NEXT;
          state_q <= S_WAIT;
        end
        S_ATT_NEXT: begin
          // floor of repeated floors equals floor of num / d^p
          att_q <= dsu_res;
          if (pc_q == pe) begin
            state_q <= S_ATT_CHK;
          end else begin
            pc_q <= pc_q + 2'd1;
            state_q <= S_ATT_DIV;
          end
        end
        S_ATT_CHK: begin
          attc_q <= att_cap;
          if (16'(att_cap) <= cutoff_q) begin
            aud_q <= 1'b0;
            state_q <= S_OUT;
          end else begin
            aud_q <= 1'b1;
            state_q <= S_VMUL;
          end
        end
        S_VMUL: state_q <= S_VOL;
        S_VOL: begin
          vol_q <= mul_q[G +: 16];
          if (d_q == DW'(1)) begin
            mix_q <= GainHalf;
            state_q <= S_PITCH0;
          end else begin
            acc_q <= '0;
            k_q <= '0;
            ph_q <= PH_DOT;
            state_q <= S_MUL;
          end
        end
        S_DOT_DIV: begin
          neg_q <= acc_q[63];
          ret_q <= S_MIX;
          state_q <= S_WAIT;
        end
        S_MIX: begin
          if (mix_w < 0) mix_q <= '0;
          else if (mix_w > $signed(65'(GainOne))) mix_q <= GainOne;
          else mix_q <= mix_w[G:0];
          state_q <= S_PITCH0;
        end
        S_PITCH0: begin
          if (first_q) begin
            first_q <= 1'b0;
            pitch_q <= PitchOne;
            state_q <= S_OUT;
          end else begin
            acc_q <= '0;
            k_q <= '0;
            ph_q <= PH_SQ_PREV;
            state_q <= S_MUL;
          end
        end
        S_PREV: begin
          dprev_q <= dsu_res[DW-1:0];
          state_q <= S_PMUL;
        end
        S_PMUL: state_q <= S_PDIV;
        S_PDIV: begin
          neg_q <= delta[DW];
          ret_q <= S_PITCH;
          state_q <= S_WAIT;
        end
        S_PITCH: begin
          if (pitch_w < 0) pitch_q <= '0;
          else if (pitch_w > $signed(65'(PitchMax))) pitch_q <= PitchMax;
          else pitch_q <= pitch_w[15:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_aud_q <= aud_q;
            out_vol_q <= aud_q ? vol_q : 16'd0;
            out_lg_q <= aud_q ? 16'(mix_q) : 16'd0;
            out_rg_q <= aud_q ? 16'(GainOne - mix_q) : 16'd0;
            out_pitch_q <= aud_q ? pitch_q : 16'd0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.audible = out_aud_q;
  assign out_if.volume_out = out_vol_q;
  assign out_if.left_gain = out_lg_q;
  assign out_if.right_gain = out_rg_q;
  assign out_if.pitch_out = out_pitch_q;

  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !dsu_sts.busy) else $error("unit busy while idle");
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> state_q == S_OUT && aud_q) else $error("history cleared early");
  a_gain_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_aud_q |-> out_lg_q + out_rg_q == 16'(GainOne))
    else $error("pan gains do not sum to one");
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_aud_q |-> out_vol_q == 16'd0 && out_pitch_q == 16'd0)
    else $error("inaudible item carries data");

endmodule
